// ===== sv/rsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

	localparam int KIND_W           = 4;
	localparam int TS_W             = 32;
	localparam int CNT_W            = 16;
	localparam int IDX_W            = 3;
	localparam int STATE_W          = 2;
	localparam int NUM_STAGES       = 5;
	localparam int STG_W            = $clog2(NUM_STAGES);
	localparam int REL_METRICS      = 7;
	localparam int FG_SLOT          = 7;
	localparam int METRIC_SLOTS_DEF = 8;

	localparam logic [CNT_W-1:0] TARGET_RESET = 16'd1000;
	localparam logic [CNT_W-1:0] CNT_MAX      = '1;
	localparam logic [TS_W-1:0]  TS_MAX       = '1;

	// event codes
	localparam logic [KIND_W-1:0] K_ARM   = 4'd0;
	localparam logic [KIND_W-1:0] K_PEND  = 4'd1;
	localparam logic [KIND_W-1:0] K_BEGIN = 4'd2;
	localparam logic [KIND_W-1:0] K_STG1  = 4'd3;
	localparam logic [KIND_W-1:0] K_STG2  = 4'd4;
	localparam logic [KIND_W-1:0] K_STG3  = 4'd5;
	localparam logic [KIND_W-1:0] K_STG4  = 4'd6;
	localparam logic [KIND_W-1:0] K_STG5  = 4'd7;
	localparam logic [KIND_W-1:0] K_END   = 4'd8;
	localparam logic [KIND_W-1:0] K_FG    = 4'd9;
	localparam logic [KIND_W-1:0] K_READ  = 4'd10;

	typedef enum logic [STATE_W-1:0] {
		RS_IDLE     = 2'd0,
		RS_ARMED    = 2'd1,
		RS_COMPLETE = 2'd2
	} run_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TS_W-1:0]   time_stamp;
		logic [TS_W-1:0]   start_stamp;
		logic [TS_W-1:0]   loop_count;
		logic [IDX_W-1:0]  metric_index;
	} evt_item_t;

	typedef struct packed {
		logic               accepted;
		logic [STATE_W-1:0] profile_state;
		logic [TS_W-1:0]    metric_total;
		logic [TS_W-1:0]    metric_maximum;
		logic [CNT_W-1:0]   captured_releases;
		logic [CNT_W-1:0]   incomplete_releases;
		logic [CNT_W-1:0]   foreground_samples;
		logic [TS_W-1:0]    loop_completions;
		logic [CNT_W-1:0]   max_loop_completions;
		logic               in_release;
	} result_t;

	function automatic logic [TS_W-1:0] sat_add32(input logic [TS_W-1:0] a,
	                                              input logic [TS_W-1:0] b);
		logic [TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TS_W] ? TS_MAX : s[TS_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rsp_evt_if;
	import rsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TS_W-1:0]   time_stamp;
	logic [TS_W-1:0]   start_stamp;
	logic [TS_W-1:0]   loop_count;
	logic [IDX_W-1:0]  metric_index;

	modport source (output valid, kind, time_stamp, start_stamp, loop_count, metric_index,
		input ready);
	modport sink (input valid, kind, time_stamp, start_stamp, loop_count, metric_index,
		output ready);
endinterface

interface rsp_res_if;
	import rsp_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [STATE_W-1:0] profile_state;
	logic [TS_W-1:0]    metric_total;
	logic [TS_W-1:0]    metric_maximum;
	logic [CNT_W-1:0]   captured_releases;
	logic [CNT_W-1:0]   incomplete_releases;
	logic [CNT_W-1:0]   foreground_samples;
	logic [TS_W-1:0]    loop_completions;
	logic [CNT_W-1:0]   max_loop_completions;
	logic               in_release;

	modport source (output valid, accepted, profile_state, metric_total, metric_maximum,
		captured_releases, incomplete_releases, foreground_samples, loop_completions,
		max_loop_completions, in_release, input ready);
	modport sink (input valid, accepted, profile_state, metric_total, metric_maximum,
		captured_releases, incomplete_releases, foreground_samples, loop_completions,
		max_loop_completions, in_release, output ready);
endinterface

interface rsp_cfg_if;
	import rsp_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/release_stage_profiler_top.sv =====
// Release stage profiler.
// evt  : event requests (kind, time_stamp, start_stamp, loop_count, metric_index).
//        Arm, pend, release begin, five chained stage marks, release end,
//        foreground span and read.
// rslt : one result request per event: accepted flag, profile state, open
//        release flag and, on a successful read, the selected metric with
//        the capture counters (zero otherwise).
// cfg  : write of target_releases, always ready; write it only while idle.
// An event is taken into the event register, evaluated in one pass of
// combinational logic and its result is registered in the result register.
// Throughput is one event per cycle while rslt is not held off, bounded by
// the single pass of subtract, saturating add and max compare between the
// event register and the result register.
// Stall: when rslt is held off, the result stays in its register and one
// more event may wait in the event register; evt.ready drops only when both
// are occupied.
// Reset (arst_n low): all profile flags and counters clear, state idle,
// target_releases returns to 1000, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module release_stage_profiler_top #(
	parameter int METRIC_SLOTS = rsp_pkg::METRIC_SLOTS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	rsp_evt_if.sink    evt,
	rsp_res_if.source  rslt,
	rsp_cfg_if.sink    cfg
);
	import rsp_pkg::*;

	localparam int SLOT_W = $clog2(METRIC_SLOTS);

	// event register and result register
	logic      evt_valid_s1;
	evt_item_t evt_s1;
	logic      res_valid_q;
	result_t   res_q;
	result_t   res_d;
	logic      advance;

	// profile state
	logic [CNT_W-1:0] target_q;
	logic             armed_q, armed_d;
	run_state_t       run_q, run_d;
	logic             pend_valid_q, pend_valid_d;
	logic [TS_W-1:0]  pend_time_q, pend_time_d;
	logic             rel_open_q, rel_open_d;
	logic             rel_pend_valid_q, rel_pend_valid_d;
	logic [TS_W-1:0]  rel_pend_time_q, rel_pend_time_d;
	logic [TS_W-1:0]  entry_time_q, entry_time_d;
	logic [NUM_STAGES-1:0] stage_valid_q, stage_valid_d;
	logic [TS_W-1:0]  stage_time_q [NUM_STAGES];
	logic [TS_W-1:0]  stage_time_d [NUM_STAGES];
	logic [TS_W-1:0]  loop_entry_q, loop_entry_d;
	logic [TS_W-1:0]  totals_q [METRIC_SLOTS];
	logic [TS_W-1:0]  totals_d [METRIC_SLOTS];
	logic [TS_W-1:0]  maxima_q [METRIC_SLOTS];
	logic [TS_W-1:0]  maxima_d [METRIC_SLOTS];
	logic [CNT_W-1:0] captured_q, captured_d;
	logic [CNT_W-1:0] incomplete_q, incomplete_d;
	logic [CNT_W-1:0] fg_count_q, fg_count_d;
	logic [CNT_W-1:0] max_loop_q, max_loop_d;
	logic [TS_W-1:0]  loop_total_q, loop_total_d;

	// datapath terms
	logic [TS_W-1:0]       rel_dur [REL_METRICS];
	logic [TS_W-1:0]       fg_dur;
	logic [TS_W-1:0]       pend_age;
	logic                  pend_ok;
	logic [TS_W-1:0]       loop_delta;
	logic [CNT_W-1:0]      loop_delta16;
	logic [NUM_STAGES-1:0] stage_prev;
	logic [STG_W-1:0]      stg;
	logic [SLOT_W-1:0]     rd_slot;

	// hold the event while the result register is occupied and not taken
	assign advance   = evt_valid_s1 && (!res_valid_q || rslt.ready);
	assign evt.ready = !evt_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= '{kind: evt.kind, time_stamp: evt.time_stamp,
				start_stamp: evt.start_stamp, loop_count: evt.loop_count,
				metric_index: evt.metric_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			target_q <= cfg.data;
		end
	end

	// durations, all modulo 2^32
	always_comb begin
		rel_dur[0] = entry_time_q - rel_pend_time_q;
		rel_dur[1] = stage_time_q[0] - entry_time_q;
		for (int k = 1; k < NUM_STAGES; k++) begin
			rel_dur[k+1] = stage_time_q[k] - stage_time_q[k-1];
		end
		rel_dur[REL_METRICS-1] = evt_s1.time_stamp - entry_time_q;
	end

	assign fg_dur       = evt_s1.time_stamp - evt_s1.start_stamp;
	assign pend_age     = evt_s1.time_stamp - pend_time_q;
	// a pend stamped after the begin is not taken
	assign pend_ok      = pend_valid_q && !pend_age[TS_W-1];
	assign loop_delta   = evt_s1.loop_count - loop_entry_q;
	assign loop_delta16 = (|loop_delta[TS_W-1:CNT_W]) ? CNT_MAX : loop_delta[CNT_W-1:0];
	// a stage mark needs the one before it; the first needs nothing
	assign stage_prev   = {stage_valid_q[NUM_STAGES-2:0], 1'b1};
	assign stg          = STG_W'(evt_s1.kind - K_STG1);
	assign rd_slot      = SLOT_W'(evt_s1.metric_index);

	always_comb begin
		logic             acc;
		logic             show;
		logic [CNT_W-1:0] cap_next;

		acc              = 1'b0;
		show             = 1'b0;
		cap_next         = sat_inc16(captured_q);
		armed_d          = armed_q;
		run_d            = run_q;
		pend_valid_d     = pend_valid_q;
		pend_time_d      = pend_time_q;
		rel_open_d       = rel_open_q;
		rel_pend_valid_d = rel_pend_valid_q;
		rel_pend_time_d  = rel_pend_time_q;
		entry_time_d     = entry_time_q;
		stage_valid_d    = stage_valid_q;
		stage_time_d     = stage_time_q;
		loop_entry_d     = loop_entry_q;
		totals_d         = totals_q;
		maxima_d         = maxima_q;
		captured_d       = captured_q;
		incomplete_d     = incomplete_q;
		fg_count_d       = fg_count_q;
		max_loop_d       = max_loop_q;
		loop_total_d     = loop_total_q;

		case (evt_s1.kind)
			K_ARM: begin
				if (!armed_q) begin
					// start a fresh capture: drop all statistics
					for (int i = 0; i < METRIC_SLOTS; i++) begin
						totals_d[i] = '0;
						maxima_d[i] = '0;
					end
					captured_d   = '0;
					incomplete_d = '0;
					fg_count_d   = '0;
					max_loop_d   = '0;
					loop_total_d = '0;
					run_d        = RS_ARMED;
					pend_valid_d = 1'b0;
					rel_open_d   = 1'b0;
					armed_d      = 1'b1;
					acc          = 1'b1;
				end
			end
			K_PEND: begin
				if (armed_q && !pend_valid_q) begin
					pend_time_d  = evt_s1.time_stamp;
					pend_valid_d = 1'b1;
					acc          = 1'b1;
				end
			end
			K_BEGIN: begin
				if (armed_q && !rel_open_q) begin
					rel_open_d       = 1'b1;
					rel_pend_valid_d = pend_ok;
					if (pend_ok) begin
						rel_pend_time_d = pend_time_q;
						pend_valid_d    = 1'b0;
					end
					stage_valid_d = '0;
					entry_time_d  = evt_s1.time_stamp;
					loop_entry_d  = evt_s1.loop_count;
					acc           = 1'b1;
				end
			end
			K_STG1, K_STG2, K_STG3, K_STG4, K_STG5: begin
				if (rel_open_q && stage_prev[stg]) begin
					stage_time_d[stg]  = evt_s1.time_stamp;
					stage_valid_d[stg] = 1'b1;
					acc                = 1'b1;
				end
			end
			K_END: begin
				if (rel_open_q) begin
					loop_total_d = sat_add32(loop_total_q, loop_delta);
					if (loop_delta16 > max_loop_q) begin
						max_loop_d = loop_delta16;
					end
					if (rel_pend_valid_q && (&stage_valid_q)) begin
						for (int i = 0; i < REL_METRICS; i++) begin
							totals_d[SLOT_W'(i)] = sat_add32(totals_q[SLOT_W'(i)], rel_dur[i]);
							if (rel_dur[i] > maxima_q[SLOT_W'(i)]) begin
								maxima_d[SLOT_W'(i)] = rel_dur[i];
							end
						end
					end else begin
						incomplete_d = sat_inc16(incomplete_q);
					end
					captured_d = cap_next;
					rel_open_d = 1'b0;
					// target reached: finish and disarm
					if (cap_next >= target_q) begin
						run_d        = RS_COMPLETE;
						armed_d      = 1'b0;
						pend_valid_d = 1'b0;
					end
					acc = 1'b1;
				end
			end
			K_FG: begin
				if (armed_q) begin
					totals_d[SLOT_W'(FG_SLOT)] = sat_add32(totals_q[SLOT_W'(FG_SLOT)], fg_dur);
					if (fg_dur > maxima_q[SLOT_W'(FG_SLOT)]) begin
						maxima_d[SLOT_W'(FG_SLOT)] = fg_dur;
					end
					fg_count_d = sat_inc16(fg_count_q);
					acc        = 1'b1;
				end
			end
			K_READ: begin
				// snapshot only once capture has completed
				if (!armed_q && run_q == RS_COMPLETE) begin
					acc  = 1'b1;
					show = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res_d               = '0;
		res_d.accepted      = acc;
		res_d.profile_state = run_d;
		res_d.in_release    = rel_open_d;
		if (show) begin
			if (int'(evt_s1.metric_index) < METRIC_SLOTS) begin
				res_d.metric_total   = totals_q[rd_slot];
				res_d.metric_maximum = maxima_q[rd_slot];
			end
			res_d.captured_releases    = captured_q;
			res_d.incomplete_releases  = incomplete_q;
			res_d.foreground_samples   = fg_count_q;
			res_d.loop_completions     = loop_total_q;
			res_d.max_loop_completions = max_loop_q;
		end
	end

	// state advances once per evaluated event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q          <= 1'b0;
			run_q            <= RS_IDLE;
			pend_valid_q     <= 1'b0;
			rel_open_q       <= 1'b0;
			rel_pend_valid_q <= 1'b0;
			stage_valid_q    <= '0;
			for (int i = 0; i < METRIC_SLOTS; i++) begin
				totals_q[i] <= '0;
				maxima_q[i] <= '0;
			end
			captured_q       <= '0;
			incomplete_q     <= '0;
			fg_count_q       <= '0;
			max_loop_q       <= '0;
			loop_total_q     <= '0;
		end else if (advance) begin
			armed_q          <= armed_d;
			run_q            <= run_d;
			pend_valid_q     <= pend_valid_d;
			rel_open_q       <= rel_open_d;
			rel_pend_valid_q <= rel_pend_valid_d;
			stage_valid_q    <= stage_valid_d;
			totals_q         <= totals_d;
			maxima_q         <= maxima_d;
			captured_q       <= captured_d;
			incomplete_q     <= incomplete_d;
			fg_count_q       <= fg_count_d;
			max_loop_q       <= max_loop_d;
			loop_total_q     <= loop_total_d;
		end
	end

	// timestamps are only read behind their valid flags
	always_ff @(posedge clk) begin
		if (advance) begin
			pend_time_q     <= pend_time_d;
			rel_pend_time_q <= rel_pend_time_d;
			entry_time_q    <= entry_time_d;
			stage_time_q    <= stage_time_d;
			loop_entry_q    <= loop_entry_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (rslt.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign rslt.valid                = res_valid_q;
	assign rslt.accepted             = res_q.accepted;
	assign rslt.profile_state        = res_q.profile_state;
	assign rslt.metric_total         = res_q.metric_total;
	assign rslt.metric_maximum       = res_q.metric_maximum;
	assign rslt.captured_releases    = res_q.captured_releases;
	assign rslt.incomplete_releases  = res_q.incomplete_releases;
	assign rslt.foreground_samples   = res_q.foreground_samples;
	assign rslt.loop_completions     = res_q.loop_completions;
	assign rslt.max_loop_completions = res_q.max_loop_completions;
	assign rslt.in_release           = res_q.in_release;

`ifndef SYNTHESIS
	a_armed_state: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> run_q == RS_ARMED)
		else $error("armed flag set outside the armed state");

	a_release_armed: assert property (@(posedge clk) disable iff (!arst_n)
		rel_open_q |-> armed_q)
		else $error("release open while not armed");

	a_pend_armed: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> armed_q)
		else $error("pend held while not armed");

	a_stage_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_valid_q & ~stage_prev) == '0)
		else $error("stage mark valid without its predecessor");

	a_snapshot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rslt.valid && !rslt.accepted) |->
		(rslt.metric_total == '0 && rslt.captured_releases == '0 &&
		rslt.loop_completions == '0))
		else $error("snapshot fields set on a refused request");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the release stage profiler. Every event request that the
// block takes is run through a local copy of the profiler state, and the
// result requests that come back are compared field by field, in order.
module testbench;
	import rsp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsp_evt_if evt_ch();
	rsp_res_if res_ch();
	rsp_cfg_if cfg_ch();

	release_stage_profiler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.rslt(res_ch),
		.cfg(cfg_ch)
	);

	always #2 clk = ~clk;

	// Stop a hung run; the slowest legal run is far shorter than this.
	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Profiler image: what the block should hold after each taken event.
	// ------------------------------------------------------------------
	logic        armed = 1'b0;
	run_state_t  phase = RS_IDLE;
	logic        pend_held = 1'b0;
	logic        rel_open = 1'b0;
	logic        rel_has_pend = 1'b0;
	logic [4:0]  stage_ok = '0;
	logic [31:0] pend_at = '0;
	logic [31:0] rel_pend_at = '0;
	logic [31:0] entry_at = '0;
	logic [31:0] loops_at_entry = '0;
	logic [31:0] loops_sum = '0;
	logic [31:0] stage_at [NUM_STAGES];
	logic [31:0] span_total [METRIC_SLOTS_DEF];
	logic [31:0] span_peak [METRIC_SLOTS_DEF];
	logic [15:0] n_captured = '0;
	logic [15:0] n_incomplete = '0;
	logic [15:0] n_fg = '0;
	logic [15:0] max_loops = '0;
	logic [15:0] target = TARGET_RESET;

	result_t expected_results [$];

	// Bench bookkeeping.
	bit steady = 1'b0;        // no idling on either side while set
	bit heavy = 1'b0;         // huge stage spans, drives the totals into saturation
	logic [31:0] now = '0;    // running time base for the releases
	int hold_left = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int reads_ok = 0;
	int releases_closed = 0;
	int sessions = 0;

	localparam int ITEM_GOAL = 630;

	function automatic logic [31:0] add_clamp(input logic [31:0] a, input logic [31:0] b);
		return (b > ~a) ? 32'hFFFF_FFFF : a + b;
	endfunction

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return v + {15'd0, ~&v};
	endfunction

	function automatic void take_sample(input int slot, input logic [31:0] d);
		span_total[slot] = add_clamp(span_total[slot], d);
		if (d > span_peak[slot])
			span_peak[slot] = d;
	endfunction

	function automatic void wipe_stats();
		for (int k = 0; k < METRIC_SLOTS_DEF; k++) begin
			span_total[k] = '0;
			span_peak[k] = '0;
		end
		n_captured = '0;
		n_incomplete = '0;
		n_fg = '0;
		max_loops = '0;
		loops_sum = '0;
	endfunction

	// Close the open release: loop stats first, then the seven spans only if
	// the pend was taken and every stage mark is in.
	function automatic void close_release(input logic [31:0] ts, input logic [31:0] loops);
		logic [31:0] loops_run;
		logic [15:0] loops16;
		loops_run = loops - loops_at_entry;
		loops16 = (loops_run > 32'h0000_FFFF) ? 16'hFFFF : loops_run[15:0];
		loops_sum = add_clamp(loops_sum, loops_run);
		if (loops16 > max_loops)
			max_loops = loops16;
		if (rel_has_pend && (&stage_ok)) begin
			take_sample(0, entry_at - rel_pend_at);
			take_sample(1, stage_at[0] - entry_at);
			for (int k = 1; k < NUM_STAGES; k++)
				take_sample(k + 1, stage_at[k] - stage_at[k - 1]);
			take_sample(REL_METRICS - 1, ts - entry_at);
		end else begin
			n_incomplete = bump16(n_incomplete);
		end
		n_captured = bump16(n_captured);
		rel_open = 1'b0;
		if (n_captured >= target) begin
			phase = RS_COMPLETE;
			armed = 1'b0;
			pend_held = 1'b0;
		end
	endfunction

	// Apply one taken event to the image and return the result it must produce.
	function automatic result_t predict_event(input evt_item_t e);
		result_t r;
		logic ok;
		logic show;
		logic [31:0] lead;
		int slot;
		r = '0;
		ok = 1'b0;
		show = 1'b0;
		case (e.kind)
			K_ARM: begin
				if (!armed) begin
					wipe_stats();
					phase = RS_ARMED;
					pend_held = 1'b0;
					rel_open = 1'b0;
					armed = 1'b1;
					ok = 1'b1;
				end
			end
			K_PEND: begin
				// a second pend while one is waiting is dropped
				if (armed && !pend_held) begin
					pend_at = e.time_stamp;
					pend_held = 1'b1;
					ok = 1'b1;
				end
			end
			K_BEGIN: begin
				if (armed && !rel_open) begin
					rel_open = 1'b1;
					// take the pend only if it does not lie ahead of the entry
					lead = e.time_stamp - pend_at;
					rel_has_pend = pend_held && !lead[31];
					if (rel_has_pend) begin
						rel_pend_at = pend_at;
						pend_held = 1'b0;
					end
					stage_ok = '0;
					entry_at = e.time_stamp;
					loops_at_entry = e.loop_count;
					ok = 1'b1;
				end
			end
			K_STG1, K_STG2, K_STG3, K_STG4, K_STG5: begin
				slot = int'(e.kind - K_STG1);
				if (rel_open && ((slot == 0) ? 1'b1 : stage_ok[slot - 1])) begin
					stage_at[slot] = e.time_stamp;
					stage_ok[slot] = 1'b1;
					ok = 1'b1;
				end
			end
			K_END: begin
				if (rel_open) begin
					close_release(e.time_stamp, e.loop_count);
					ok = 1'b1;
				end
			end
			K_FG: begin
				if (armed) begin
					take_sample(FG_SLOT, e.time_stamp - e.start_stamp);
					n_fg = bump16(n_fg);
					ok = 1'b1;
				end
			end
			K_READ: begin
				if (!armed && phase == RS_COMPLETE) begin
					ok = 1'b1;
					show = 1'b1;
				end
			end
			default: ;
		endcase
		r.accepted = ok;
		r.profile_state = phase;
		if (show) begin
			r.metric_total = span_total[e.metric_index];
			r.metric_maximum = span_peak[e.metric_index];
			r.captured_releases = n_captured;
			r.incomplete_releases = n_incomplete;
			r.foreground_samples = n_fg;
			r.loop_completions = loops_sum;
			r.max_loop_completions = max_loops;
		end
		r.in_release = rel_open;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls, and the in-order check of every result.
	// ------------------------------------------------------------------
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drop ready for a random stretch now and then; keep it high while steady.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 2) == 0) begin
			hold_left <= pause_len();
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_mismatch(what, want, got);
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.accepted, res_ch.profile_state, res_ch.metric_total,
				res_ch.metric_maximum, res_ch.captured_releases, res_ch.incomplete_releases,
				res_ch.foreground_samples, res_ch.loop_completions,
				res_ch.max_loop_completions, res_ch.in_release};
			if (expected_results.size() == 0) begin
				note_mismatch("unrequested result", '0, {31'd0, got.accepted});
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("accepted", want.accepted, got.accepted);
				check_field("profile_state", want.profile_state, got.profile_state);
				check_field("metric_total", want.metric_total, got.metric_total);
				check_field("metric_maximum", want.metric_maximum, got.metric_maximum);
				check_field("captured_releases", want.captured_releases,
					got.captured_releases);
				check_field("incomplete_releases", want.incomplete_releases,
					got.incomplete_releases);
				check_field("foreground_samples", want.foreground_samples,
					got.foreground_samples);
				check_field("loop_completions", want.loop_completions, got.loop_completions);
				check_field("max_loop_completions", want.max_loop_completions,
					got.max_loop_completions);
				check_field("in_release", want.in_release, got.in_release);
			end
		end
	end

	// ------------------------------------------------------------------
	// Event side.
	// ------------------------------------------------------------------

	// Send one event request. Valid stays high into the next request when there
	// is no gap, so back-to-back requests never see valid dip.
	task automatic send_event(input logic [KIND_W-1:0] kind, input logic [TS_W-1:0] ts,
			input logic [TS_W-1:0] ss, input logic [TS_W-1:0] loops,
			input logic [IDX_W-1:0] idx);
		int gap;
		evt_item_t e;
		result_t r;
		e.kind = kind;
		e.time_stamp = ts;
		e.start_stamp = ss;
		e.loop_count = loops;
		e.metric_index = idx;
		gap = pause_len();
		if (gap != 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.kind <= e.kind;
		evt_ch.time_stamp <= e.time_stamp;
		evt_ch.start_stamp <= e.start_stamp;
		evt_ch.loop_count <= e.loop_count;
		evt_ch.metric_index <= e.metric_index;
		// hold the request until the block takes it
		do @(posedge clk); while (!evt_ch.ready);
		r = predict_event(e);
		expected_results.push_back(r);
		items_sent++;
		if (r.accepted && kind == K_READ)
			reads_ok++;
		if (r.accepted && kind == K_END)
			releases_closed++;
	endtask

	// Drop valid and let every outstanding result come back.
	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write target_releases; only done with nothing in flight.
	task automatic write_target(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		target = value;
	endtask

	// Advance the time base: mostly short spans, some long, a few arbitrary; all huge while heavy.
	function automatic logic [31:0] next_span();
		int r;
		r = $urandom_range(0, 99);
		if (heavy)
			return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
		if (r < 70)
			return $urandom_range(1, 200);
		if (r < 90)
			return $urandom_range(0, 1 << 20);
		return $urandom();
	endfunction

	function automatic logic [31:0] loops_in_release();
		int r;
		r = $urandom_range(0, 99);
		if (heavy || r < 5)
			return $urandom();
		if (r < 20)
			return $urandom_range(0, 200000);
		return $urandom_range(0, 50);
	endfunction

	// Noise: a foreground span in four of ten cases, otherwise any kind with random fields.
	task automatic noise_event();
		if ($urandom_range(0, 9) < 4)
			send_event(K_FG, now, now - next_span(), $urandom(), IDX_W'($urandom()));
		else
			send_event(KIND_W'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom(),
				IDX_W'($urandom()));
	endtask

	// One release with random content: usually a pend and all five marks,
	// sometimes a missing pend, a pend stamped ahead, missing or repeated marks.
	task automatic run_release();
		int r;
		int marks;
		logic [31:0] base_loops;
		r = $urandom_range(0, 99);
		if (r < 75)
			send_event(K_PEND, now, $urandom(), $urandom(), IDX_W'($urandom()));
		else if (r < 85)
			send_event(K_PEND, now + 32'd500 + $urandom_range(0, 1 << 24), $urandom(),
				$urandom(), IDX_W'($urandom()));
		now += next_span();
		base_loops = $urandom();
		send_event(K_BEGIN, now, $urandom(), base_loops, IDX_W'($urandom()));
		marks = ($urandom_range(0, 9) < 8) ? NUM_STAGES : $urandom_range(0, NUM_STAGES - 1);
		for (int k = 0; k < marks; k++) begin
			if ($urandom_range(0, 14) == 0)
				noise_event();
			now += next_span();
			send_event(KIND_W'(K_STG1 + k), now, $urandom(), $urandom(), IDX_W'($urandom()));
			// a repeated mark overwrites its own stage only
			if ($urandom_range(0, 19) == 0) begin
				now += next_span();
				send_event(KIND_W'(K_STG1 + k), now, $urandom(), $urandom(),
					IDX_W'($urandom()));
			end
		end
		// a mark that skips a stage must be refused
		if (marks < NUM_STAGES - 1 && $urandom_range(0, 1) == 0)
			send_event(KIND_W'(K_STG1 + marks + 1), now, $urandom(), $urandom(),
				IDX_W'($urandom()));
		now += next_span();
		send_event(K_END, now, $urandom(), base_loops + loops_in_release(),
			IDX_W'($urandom()));
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Nothing may act before the first arm; unused kinds are ignored too.
	task automatic test_unarmed_events();
		send_event(K_READ, 32'h0, 32'h0, 32'h0, 3'd0);
		send_event(K_PEND, 32'hFFFF_FFFF, 32'h0, 32'h0, 3'd7);
		send_event(K_BEGIN, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
		send_event(K_STG1, 32'h1, 32'h0, 32'h0, 3'd0);
		send_event(K_END, 32'h2, 32'h0, 32'h0, 3'd0);
		send_event(K_FG, 32'h10, 32'h0, 32'h0, 3'd0);
		send_event(KIND_W'(15), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
	endtask

	// One full profile of two releases: the first complete with a wrapped pend,
	// refused and repeated marks; the second with its pend stamped ahead.
	task automatic test_armed_profile();
		write_target(16'd2);
		send_event(K_ARM, 32'h0, 32'h0, 32'h0, 3'd0);
		send_event(K_ARM, 32'h0, 32'h0, 32'h0, 3'd0);
		send_event(K_PEND, 32'hFFFF_FFF0, 32'h0, 32'h0, 3'd0);
		send_event(K_PEND, 32'h5, 32'h0, 32'h0, 3'd0);
		send_event(K_BEGIN, 32'h10, 32'h0, 32'hFFFF_FFF0, 3'd0);
		send_event(K_STG2, 32'h18, 32'h0, 32'h0, 3'd0);
		send_event(K_STG1, 32'h20, 32'h0, 32'h0, 3'd0);
		send_event(K_STG2, 32'h28, 32'h0, 32'h0, 3'd0);
		send_event(K_STG2, 32'h30, 32'h0, 32'h0, 3'd0);
		send_event(K_STG3, 32'h40, 32'h0, 32'h0, 3'd0);
		send_event(K_STG4, 32'h50, 32'h0, 32'h0, 3'd0);
		send_event(K_STG5, 32'h60, 32'h0, 32'h0, 3'd0);
		send_event(K_END, 32'h1000, 32'h0, 32'h10, 3'd0);
		send_event(K_FG, 32'h0, 32'hFFFF_FFFF, 32'h0, 3'd0);
		send_event(K_FG, 32'hFFFF_FFFF, 32'h0, 32'h0, 3'd0);
		send_event(K_PEND, 32'h2000, 32'h0, 32'h0, 3'd0);
		send_event(K_BEGIN, 32'h1800, 32'h0, 32'hFFFF_FFFF, 3'd0);
		for (int k = 0; k < NUM_STAGES; k++)
			send_event(KIND_W'(K_STG1 + k), 32'h1810 + k, 32'h0, 32'h0, 3'd0);
		send_event(K_END, 32'h1900, 32'h0, 32'hFFFF_FFFF, 3'd0);
		send_event(K_READ, 32'h0, 32'h0, 32'h0, 3'd0);
		send_event(K_READ, 32'h0, 32'h0, 32'h0, 3'd6);
		send_event(K_READ, 32'h0, 32'h0, 32'h0, 3'd7);
	endtask

	// Sessions of random releases with noise mixed in, each under its own
	// target; the first ones take the extreme targets.
	task automatic test_random_profiles();
		logic [CNT_W-1:0] tgt;
		int rel_cap;
		while (items_sent < ITEM_GOAL) begin
			case (sessions)
				0: tgt = 16'hFFFF;
				1: tgt = 16'd1;
				2: tgt = 16'd0;
				default: tgt = CNT_W'($urandom_range(1, 6));
			endcase
			write_target(tgt);
			steady = ($urandom_range(0, 4) == 0);
			heavy = ($urandom_range(0, 3) == 0);
			send_event(K_ARM, $urandom(), $urandom(), $urandom(), IDX_W'($urandom()));
			rel_cap = 8;
			while (armed && rel_cap > 0) begin
				run_release();
				if ($urandom_range(0, 2) == 0)
					noise_event();
				rel_cap--;
			end
			repeat ($urandom_range(2, 6))
				send_event(K_READ, $urandom(), $urandom(), $urandom(), IDX_W'($urandom()));
			if ($urandom_range(0, 1) == 0)
				noise_event();
			steady = 1'b0;
			heavy = 1'b0;
			sessions++;
		end
	endtask

	initial begin
		evt_ch.valid = 1'b0;
		evt_ch.kind = '0;
		evt_ch.time_stamp = '0;
		evt_ch.start_stamp = '0;
		evt_ch.loop_count = '0;
		evt_ch.metric_index = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int k = 0; k < NUM_STAGES; k++)
			stage_at[k] = '0;
		wipe_stats();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unarmed_events();
		test_armed_profile();
		test_random_profiles();

		// let the last results come home, then idle before the report
		wait_drained();
		repeat (8) @(posedge clk);

		$display("covered %0d event requests in %0d profiling sessions, %0d results checked",
			items_sent, sessions, results_checked);
		$display("closed %0d releases, %0d reads returned a snapshot, %0d mismatches",
			releases_closed, reads_ok, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rsp_pkg.sv
sv/rsp_if.sv
sv/release_stage_profiler_top.sv
test/testbench.sv
